// ===== rtl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
package i2cm_pkg;

    // Command codes as carried in the mode field.
    typedef enum logic [2:0] {
        CMD_START    = 3'd0,
        CMD_STOP     = 3'd1,
        CMD_WRITE    = 3'd2,
        CMD_WAIT_ACK = 3'd3,
        CMD_READ     = 3'd4
    } cmd_t;

    // Sequencer phases, one-hot.
    typedef enum logic [13:0] {
        PH_IDLE  = 14'b00000000000001,
        PH_ST1   = 14'b00000000000010,
        PH_ST2   = 14'b00000000000100,
        PH_SP1   = 14'b00000000001000,
        PH_SP2   = 14'b00000000010000,
        PH_WHIGH = 14'b00000000100000,
        PH_WLOW  = 14'b00000001000000,
        PH_WNEXT = 14'b00000010000000,
        PH_K1    = 14'b00000100000000,
        PH_KPOLL = 14'b00001000000000,
        PH_RHIGH = 14'b00010000000000,
        PH_RNEXT = 14'b00100000000000,
        PH_AHIGH = 14'b01000000000000,
        PH_ALOW  = 14'b10000000000000
    } phase_t;

    // One classified tick as it travels from the front end to the engine.
    typedef struct packed {
        logic       go;
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } tick_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_UNIT_TICKS  = 2'd0;
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;

    localparam logic [15:0] UNIT_TICKS_RESET  = 16'd8;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

    // Hold lengths, stored as the number of units minus one.
    localparam logic [1:0] HOLD_1 = 2'd0;
    localparam logic [1:0] HOLD_2 = 2'd1;
    localparam logic [1:0] HOLD_4 = 2'd3;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

// ===== rtl/i2cm_tick_if.sv =====
// Input channel carrying one tick request per transfer.
interface i2cm_tick_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, cmd_valid, mode, tx_byte, send_ack, sda_in, input ready);
    modport sink (input valid, cmd_valid, mode, tx_byte, send_ack, sda_in, output ready);
endinterface

// ===== rtl/i2cm_res_if.sv =====
// Output channel carrying one pin and status request per tick.
interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_output_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;

    modport source (output valid, scl_level, sda_level, sda_output_enable, busy_res,
                    done_res, rx_byte, ack_error, input ready);
    modport sink (input valid, scl_level, sda_level, sda_output_enable, busy_res,
                  done_res, rx_byte, ack_error, output ready);
endinterface

// ===== rtl/i2cm_cfg_if.sv =====
// Configuration write channel.
interface i2cm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine: configuration registers and the two halves.
//
//   Channel   Dir  Handshake          Contents
//   in_ch     in   valid/ready        one tick: cmd_valid, mode, tx_byte, send_ack, sda_in
//   out_ch    out  valid/ready        pin levels, SDA enable, busy, done, rx_byte, ack_error
//   cfg_ch    in   valid/ready        register write: index, data
//
// Every tick request yields exactly one result request. The engine retires one tick per
// clock cycle while the output is not stalled; a tick passes through a queue entry, then
// the result register; a steady stream passes at one per cycle through the two-entry queue.
// Reset (rst_n low, asynchronous) idles the engine with SCL high and SDA driven high, and
// loads unit_ticks with 8 and ack_timeout with 250. A stalled output holds the engine,
// and the queue absorbs input until it is full; configuration writes are always taken.
module i2c_master_bit_engine (
    input  logic        clk,
    input  logic        rst_n,
    i2cm_tick_if.sink   in_ch,
    i2cm_res_if.source  out_ch,
    i2cm_cfg_if.sink    cfg_ch
);
    import i2cm_pkg::*;

    logic [15:0] unit_ticks_reg;
    logic [7:0]  ack_timeout_reg;
    tick_t       head;
    logic        head_valid;
    logic        pop;

    assign cfg_ch.ready = 1'b1;

    // Writes to indexes beyond the two registers are accepted and dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg  <= UNIT_TICKS_RESET;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_ch.valid)
        begin
            if (cfg_ch.index == REG_UNIT_TICKS)
            begin
                unit_ticks_reg <= cfg_ch.data;
            end
            else if (cfg_ch.index == REG_ACK_TIMEOUT)
            begin
                ack_timeout_reg <= cfg_ch.data[7:0];
            end
        end
    end

    // Front end: decodes the command field and queues the tick.
    i2cm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    // Back end: plays the pin sequence and presents the registered result.
    i2cm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .unit_ticks  (unit_ticks_reg),
        .ack_timeout (ack_timeout_reg),
        .out_ch      (out_ch)
    );

endmodule

// ===== rtl/i2cm_front.sv =====
// Front end: classifies incoming ticks and queues them for the engine.
module i2cm_front (
    input  logic           clk,
    input  logic           rst_n,
    i2cm_tick_if.sink      in_ch,
    output i2cm_pkg::tick_t head,
    output logic           head_valid,
    input  logic           pop
);
    import i2cm_pkg::*;

    tick_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    tick_t      classified;

    assign in_ch.ready = (count_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;

    // Only modes that name a command start anything; the rest are plain ticks.
    always_comb
    begin
        classified.go       = in_ch.cmd_valid && (in_ch.mode <= CMD_READ);
        classified.cmd      = cmd_t'(in_ch.mode);
        classified.tx_byte  = in_ch.tx_byte;
        classified.send_ack = in_ch.send_ack;
        classified.sda_in   = in_ch.sda_in;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != 2'd0);

endmodule

// ===== rtl/i2cm_back.sv =====
// Back end: the pin sequencer, advancing one queued tick per cycle while the output is not stalled.
module i2cm_back (
    input  logic            clk,
    input  logic            rst_n,
    input  i2cm_pkg::tick_t head,
    input  logic            head_valid,
    output logic            pop,
    input  logic [15:0]     unit_ticks,
    input  logic [7:0]      ack_timeout,
    i2cm_res_if.source      out_ch
);
    import i2cm_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic        is_ack_reg, is_ack_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg,  shift_next;
    logic [15:0] delay_reg,  delay_next;
    logic [1:0]  units_reg,  units_next;
    logic [7:0]  poll_reg,   poll_next;
    logic        scl_reg,    scl_next;
    logic        sda_reg,    sda_next;
    logic        oe_reg,     oe_next;
    logic        ack_choice_reg, ack_choice_next;
    logic [7:0]  rx_reg,     rx_next;
    logic        done_reg,   done_next;
    logic        err_reg,    err_next;
    logic        out_valid_reg;

    logic [15:0] unit_load;
    logic        expired;
    logic        do_wait;
    logic [1:0]  wait_units;
    logic [3:0]  bit_inc;
    logic [8:0]  poll_inc;

    assign pop       = head_valid && (!out_valid_reg || out_ch.ready);
    assign unit_load = (unit_ticks == 16'd0) ? 16'd1 : unit_ticks;
    assign bit_inc   = bit_count_reg + 4'd1;
    assign poll_inc  = {1'b0, poll_reg} + 9'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        is_ack_next     = is_ack_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        delay_next      = delay_reg;
        units_next      = units_reg;
        poll_next       = poll_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        oe_next         = oe_reg;
        ack_choice_next = ack_choice_reg;
        rx_next         = rx_reg;
        done_next       = 1'b0;
        err_next        = 1'b0;
        expired         = 1'b0;
        do_wait         = 1'b0;
        wait_units      = HOLD_1;

        if (phase_reg == PH_IDLE)
        begin
            if (head.go)
            begin
                is_ack_next = (head.cmd == CMD_WAIT_ACK);
                case (head.cmd)
                    CMD_START:
                    begin
                        oe_next = 1'b1; sda_next = 1'b1; scl_next = 1'b1;
                        do_wait = 1'b1; wait_units = HOLD_4; phase_next = PH_ST1;
                    end
                    CMD_STOP:
                    begin
                        oe_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
                        do_wait = 1'b1; wait_units = HOLD_4; phase_next = PH_SP1;
                    end
                    CMD_WRITE:
                    begin
                        bit_count_next = 4'd0;
                        oe_next = 1'b1; scl_next = 1'b0;
                        sda_next   = head.tx_byte[7];
                        shift_next = {head.tx_byte[6:0], 1'b0};
                        do_wait = 1'b1; wait_units = HOLD_2; phase_next = PH_WHIGH;
                    end
                    CMD_WAIT_ACK:
                    begin
                        poll_next = 8'd0;
                        oe_next = 1'b0; sda_next = 1'b1;
                        do_wait = 1'b1; wait_units = HOLD_1; phase_next = PH_K1;
                    end
                    default:
                    begin
                        ack_choice_next = head.send_ack;
                        bit_count_next  = 4'd0;
                        shift_next      = 8'd0;
                        oe_next = 1'b0; scl_next = 1'b0;
                        do_wait = 1'b1; wait_units = HOLD_2; phase_next = PH_RHIGH;
                    end
                endcase
            end
        end
        else
        begin
            // The acknowledge poll runs every tick; all other phases wait out their hold.
            if (phase_reg == PH_KPOLL)
            begin
                expired = 1'b1;
            end
            else if (delay_reg > 16'd1)
            begin
                delay_next = delay_reg - 16'd1;
            end
            else if (units_reg != 2'd0)
            begin
                units_next = units_reg - 2'd1;
                delay_next = unit_load;
            end
            else
            begin
                expired = 1'b1;
            end

            if (expired)
            begin
                case (phase_reg)
                    PH_ST1:
                    begin
                        sda_next = 1'b0;
                        do_wait = 1'b1; wait_units = HOLD_4; phase_next = PH_ST2;
                    end
                    PH_ST2:
                    begin
                        scl_next = 1'b0; phase_next = PH_IDLE; done_next = 1'b1;
                    end
                    PH_SP1:
                    begin
                        scl_next = 1'b1; sda_next = 1'b1;
                        do_wait = 1'b1; wait_units = HOLD_4; phase_next = PH_SP2;
                    end
                    PH_SP2:
                    begin
                        err_next = is_ack_reg; phase_next = PH_IDLE; done_next = 1'b1;
                    end
                    PH_WHIGH:
                    begin
                        scl_next = 1'b1;
                        do_wait = 1'b1; wait_units = HOLD_2; phase_next = PH_WLOW;
                    end
                    PH_WLOW:
                    begin
                        scl_next = 1'b0;
                        do_wait = 1'b1; wait_units = HOLD_2; phase_next = PH_WNEXT;
                    end
                    PH_WNEXT:
                    begin
                        bit_count_next = bit_inc;
                        if (bit_inc >= BITS_PER_BYTE)
                        begin
                            phase_next = PH_IDLE; done_next = 1'b1;
                        end
                        else
                        begin
                            sda_next   = shift_reg[7];
                            shift_next = {shift_reg[6:0], 1'b0};
                            do_wait = 1'b1; wait_units = HOLD_2; phase_next = PH_WHIGH;
                        end
                    end
                    PH_K1:
                    begin
                        scl_next = 1'b1;
                        do_wait = 1'b1; wait_units = HOLD_1; phase_next = PH_KPOLL;
                    end
                    PH_KPOLL:
                    begin
                        if (!head.sda_in)
                        begin
                            scl_next = 1'b0; phase_next = PH_IDLE; done_next = 1'b1;
                        end
                        else if (poll_inc > {1'b0, ack_timeout})
                        begin
                            // Timed out: release the bus with a stop sequence.
                            oe_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
                            do_wait = 1'b1; wait_units = HOLD_4; phase_next = PH_SP1;
                        end
                        else
                        begin
                            poll_next = poll_inc[7:0];
                        end
                    end
                    PH_RHIGH:
                    begin
                        scl_next       = 1'b1;
                        shift_next     = {shift_reg[6:0], head.sda_in};
                        bit_count_next = bit_inc;
                        do_wait = 1'b1; wait_units = HOLD_1; phase_next = PH_RNEXT;
                    end
                    PH_RNEXT:
                    begin
                        scl_next = 1'b0;
                        do_wait = 1'b1; wait_units = HOLD_2;
                        if (bit_count_reg >= BITS_PER_BYTE)
                        begin
                            oe_next    = 1'b1;
                            sda_next   = !ack_choice_reg;
                            phase_next = PH_AHIGH;
                        end
                        else
                        begin
                            phase_next = PH_RHIGH;
                        end
                    end
                    PH_AHIGH:
                    begin
                        scl_next = 1'b1;
                        do_wait = 1'b1; wait_units = HOLD_2; phase_next = PH_ALOW;
                    end
                    PH_ALOW:
                    begin
                        scl_next = 1'b0; rx_next = shift_reg;
                        phase_next = PH_IDLE; done_next = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        if (do_wait)
        begin
            units_next = wait_units;
            delay_next = unit_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            is_ack_reg     <= 1'b0;
            bit_count_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            delay_reg      <= 16'd0;
            units_reg      <= 2'd0;
            poll_reg       <= 8'd0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            oe_reg         <= 1'b1;
            ack_choice_reg <= 1'b0;
            rx_reg         <= 8'd0;
            done_reg       <= 1'b0;
            err_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg      <= phase_next;
                is_ack_reg     <= is_ack_next;
                bit_count_reg  <= bit_count_next;
                shift_reg      <= shift_next;
                delay_reg      <= delay_next;
                units_reg      <= units_next;
                poll_reg       <= poll_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                oe_reg         <= oe_next;
                ack_choice_reg <= ack_choice_next;
                rx_reg         <= rx_next;
                done_reg       <= done_next;
                err_reg        <= err_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The engine state only moves when a result is produced, so it doubles as the result.
    assign out_ch.valid             = out_valid_reg;
    assign out_ch.scl_level         = scl_reg;
    assign out_ch.sda_level         = sda_reg;
    assign out_ch.sda_output_enable = oe_reg;
    assign out_ch.busy_res          = (phase_reg != PH_IDLE);
    assign out_ch.done_res          = done_reg;
    assign out_ch.rx_byte           = rx_reg;
    assign out_ch.ack_error         = err_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (phase_reg == PH_IDLE))
        else $error("done reported while a command is still running");

    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> (done_reg && is_ack_reg))
        else $error("ack error outside the end of a wait-ack command");

    a_poll_pins: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_KPOLL) |-> (scl_reg && !oe_reg))
        else $error("acknowledge poll with SCL low or SDA driven");

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= BITS_PER_BYTE)
        else $error("bit count ran past one byte");

endmodule
